// File: rtl/pfba_pkg.sv
package pfba_pkg;

	// Map geometry: one bit per page, 32 pages per map word.
	localparam int MAP_WORDS = 1024;
	localparam int WORD_BITS = 32;
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam int WORD_W = $clog2(MAP_WORDS);
	localparam int PAGE_W = 15;
	// Summary store: one bit per map word, telling whether that word holds a free page.
	localparam int SUM_ROWS = MAP_WORDS / WORD_BITS;
	localparam int SUM_W = $clog2(SUM_ROWS);

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_FREE = 2'd1;
	localparam logic [1:0] KIND_MARK_USED = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic found;
		logic [PAGE_W-1:0] granted_page;
	} rsp_t;

	typedef struct packed {
		logic map_we;
		logic [WORD_W-1:0] map_addr;
		logic [WORD_BITS-1:0] map_wdata;
		logic sum_we;
		logic [SUM_W-1:0] sum_addr;
		logic [WORD_BITS-1:0] sum_wdata;
	} mem_ctl_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SUM_RD,
		S_SUM_ENC,
		S_MAP_RD,
		S_MAP_ENC,
		S_SUM_UPD,
		S_DONE
	} state_t;

endpackage

// File: rtl/page_frame_bitmap_allocator_core.sv
// Page frame bitmap allocator, first fit.
// req channel (valid/ready) carries {kind, page_number}: allocate, free or mark-used.
// rsp channel (valid/ready) returns {found, granted_page}, one transfer per request.
// Storage: a 1024 x 32 free bitmap (1 = free page), a 32 x 32 summary store with one
// bit per map word that is nonzero, and a 32-bit register with one bit per nonzero
// summary row. Allocate walks the three levels with one shared find-first-set unit.
// Sequence: the top-level encode runs in the req transfer cycle. Allocate then runs
// summary read, summary encode, map read, map encode and write, summary update and
// result load; free and mark-used run from map read on (no summary lookup); an
// allocate with no free page or an unknown kind goes straight to result load.
// One request is in flight at a time; req_ready is high only while idle, so the
// next request is taken only once the walk of the last one has loaded its result.
// Reset: every page reads as used. After arst_n releases, a clearing pass writes
// zero to all 1024 map words (and the summary rows), with req_ready low.
// A stalled receiver holds the result in the rsp register; the block may take the
// next request meanwhile and parks its result until the rsp register frees up.
module page_frame_bitmap_allocator_core
	import pfba_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output rsp_t rsp
);

	state_t state_q, state_d;
	logic [WORD_W-1:0] clr_q;
	logic [1:0] kind_q;
	logic [WORD_W-1:0] word_q;
	logic [BIT_W-1:0] bit_q;
	logic nz_q;
	logic [SUM_ROWS-1:0] top_q;
	logic res_found_q;
	logic [PAGE_W-1:0] res_page_q;
	logic rsp_valid_q;
	rsp_t rsp_q;

	mem_ctl_t mem_ctl;
	logic [WORD_BITS-1:0] map_rdata, sum_rdata;
	logic [WORD_BITS-1:0] ffs_vec;
	logic ffs_any;
	logic [BIT_W-1:0] ffs_idx;

	logic req_xfer, rsp_free, is_alloc;
	logic [BIT_W-1:0] bit_sel;
	logic [WORD_BITS-1:0] bit_mask, map_new, sum_new;
	logic [SUM_ROWS-1:0] top_in;

	assign req_xfer = req_valid && req_ready;
	assign rsp_free = !rsp_valid_q || rsp_ready;
	assign is_alloc = (kind_q == KIND_ALLOC);

	pfba_store u_store (
		.clk(clk),
		.ctl(mem_ctl),
		.map_rdata(map_rdata),
		.sum_rdata(sum_rdata)
	);

	pfba_ffs u_ffs (
		.vec(ffs_vec),
		.any(ffs_any),
		.idx(ffs_idx)
	);

	// Top-level register padded to a full word for the shared encoder.
	assign top_in = top_q;

	// Allocate takes the lowest free bit of the word just read; free and mark-used
	// take the bit from the request.
	assign bit_sel = is_alloc ? ffs_idx : bit_q;
	assign bit_mask = WORD_BITS'(1) << bit_sel;
	always_comb begin
		case (kind_q)
			KIND_FREE: map_new = map_rdata | bit_mask;
			default: map_new = map_rdata & ~bit_mask;
		endcase
	end

	// Summary row with this word's bit replaced by whether the word is still nonzero.
	always_comb begin
		sum_new = sum_rdata;
		sum_new[word_q[BIT_W-1:0]] = nz_q;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == WORD_W'(MAP_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					case (req.kind)
						KIND_ALLOC: state_d = ffs_any ? S_SUM_RD : S_DONE;
						KIND_FREE, KIND_MARK_USED: state_d = S_MAP_RD;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SUM_RD: state_d = S_SUM_ENC;
			S_SUM_ENC: state_d = S_MAP_RD;
			S_MAP_RD: state_d = S_MAP_ENC;
			S_MAP_ENC: state_d = S_SUM_UPD;
			S_SUM_UPD: state_d = S_DONE;
			S_DONE: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// Outputs of the sequencer: memory port control, encoder input and req_ready.
	always_comb begin
		mem_ctl = '0;
		ffs_vec = '0;
		req_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mem_ctl.map_we = 1'b1;
				mem_ctl.map_addr = clr_q;
				mem_ctl.sum_we = 1'b1;
				mem_ctl.sum_addr = clr_q[SUM_W-1:0];
			end
			S_IDLE: begin
				req_ready = 1'b1;
				ffs_vec = WORD_BITS'(top_in);
			end
			S_SUM_RD: begin
				mem_ctl.sum_addr = word_q[WORD_W-1:BIT_W];
			end
			S_SUM_ENC: begin
				ffs_vec = sum_rdata;
			end
			S_MAP_RD: begin
				mem_ctl.map_addr = word_q;
			end
			S_MAP_ENC: begin
				ffs_vec = map_rdata;
				mem_ctl.map_we = 1'b1;
				mem_ctl.map_addr = word_q;
				mem_ctl.map_wdata = map_new;
				mem_ctl.sum_addr = word_q[WORD_W-1:BIT_W];
			end
			S_SUM_UPD: begin
				mem_ctl.sum_we = 1'b1;
				mem_ctl.sum_addr = word_q[WORD_W-1:BIT_W];
				mem_ctl.sum_wdata = sum_new;
			end
			default: begin
				mem_ctl = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			top_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + WORD_W'(1);
			end
			// Keep the top level in step with the summary row just written.
			if (state_q == S_SUM_UPD) begin
				top_q[word_q[WORD_W-1:BIT_W]] <= |sum_new;
			end
			if (state_q == S_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload.
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			kind_q <= req.kind;
			bit_q <= req.page_number[BIT_W-1:0];
			res_page_q <= '0;
			// A 15-bit page number always falls inside the 1024-word map.
			res_found_q <= (req.kind == KIND_FREE) || (req.kind == KIND_MARK_USED);
			if (req.kind == KIND_ALLOC) begin
				word_q <= {ffs_idx[SUM_W-1:0], BIT_W'(0)};
			end else begin
				word_q <= req.page_number[PAGE_W-1:BIT_W];
			end
		end
		if (state_q == S_SUM_ENC) begin
			word_q[BIT_W-1:0] <= ffs_idx;
		end
		if (state_q == S_MAP_ENC) begin
			nz_q <= |map_new;
			if (is_alloc) begin
				res_found_q <= 1'b1;
				res_page_q <= PAGE_W'({word_q, ffs_idx});
			end
		end
		if (state_q == S_DONE && rsp_free) begin
			rsp_q.found <= res_found_q;
			rsp_q.granted_page <= res_page_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	// A result appears only out of the result-load step.
	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_DONE))
		else $error("rsp_valid rose outside the result-load step");

	// The summary levels led allocate to this word, so it must hold a free page.
	a_alloc_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAP_ENC) && (kind_q == KIND_ALLOC) |-> ffs_any)
		else $error("allocate reached an empty map word");

	// Nothing granted means page zero is reported.
	a_no_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.found |-> rsp_q.granted_page == '0)
		else $error("granted_page nonzero on a not-found result");
`endif

endmodule

// File: rtl/pfba_ffs.sv
module pfba_ffs
	import pfba_pkg::*;
(
	input logic [WORD_BITS-1:0] vec,
	output logic any,
	output logic [BIT_W-1:0] idx
);

	// Lowest set bit wins: scan from the top so lower bits overwrite.
	always_comb begin
		idx = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (vec[j]) begin
				idx = BIT_W'(j);
			end
		end
	end

	assign any = |vec;

endmodule

// File: rtl/pfba_store.sv
module pfba_store
	import pfba_pkg::*;
(
	input logic clk,
	input mem_ctl_t ctl,
	output logic [WORD_BITS-1:0] map_rdata,
	output logic [WORD_BITS-1:0] sum_rdata
);

	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] sum_mem [SUM_ROWS];

	always_ff @(posedge clk) begin
		if (ctl.map_we) begin
			map_mem[ctl.map_addr] <= ctl.map_wdata;
		end
		map_rdata <= map_mem[ctl.map_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_we) begin
			sum_mem[ctl.sum_addr] <= ctl.sum_wdata;
		end
		sum_rdata <= sum_mem[ctl.sum_addr];
	end

endmodule

// File: test/page_frame_bitmap_allocator_core_tb.sv
`timescale 1ns / 100ps

module page_frame_bitmap_allocator_core_tb;
	import pfba_pkg::*;

	// Kind 3 has no meaning; the block must answer it with an empty result.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int TOP_PAGE = (1 << PAGE_W) - 1;
	// Width of the page window that most random traffic lands in: six map words.
	localparam int HOT_SPAN = 192;
	// Allows for the clearing pass and every stall, many times over.
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Own copy of the free bitmap: 1 means the page is free.
	logic [WORD_BITS-1:0] frame_free [MAP_WORDS] = '{default: '0};
	// Responses the block owes, oldest first.
	rsp_t owed_responses [$];
	rsp_t owed_head;

	int send_gap_pct = 0;
	int rcv_stall_pct = 0;
	int unsigned hot_base = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	page_frame_bitmap_allocator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #4 clk = ~clk;

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Hang guard: end the run if the block stops moving.
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("%0t: timeout with %0d responses outstanding", $time, owed_responses.size());
		$display("page_frame_bitmap_allocator_core_tb failed");
		$finish;
	end

	// Stall the response side at random; the rate is set per phase.
	always @(posedge clk)
		rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);

	task automatic flag_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Apply one request to the bitmap copy and return the response it must produce.
	function automatic rsp_t apply_request(input req_t item);
		rsp_t outcome;
		int word_idx;
		int bit_idx;
		outcome = '0;
		word_idx = int'(item.page_number) / WORD_BITS;
		bit_idx = int'(item.page_number) % WORD_BITS;
		case (item.kind)
			KIND_ALLOC: begin
				// First fit: lowest nonzero word, then its lowest free bit.
				for (int w = 0; w < MAP_WORDS; w++) begin
					if (!outcome.found && frame_free[w] != '0) begin
						for (int b = WORD_BITS - 1; b >= 0; b--)
							if (frame_free[w][b])
								bit_idx = b;
						frame_free[w][bit_idx] = 1'b0;
						outcome.found = 1'b1;
						outcome.granted_page = PAGE_W'(w * WORD_BITS + bit_idx);
					end
				end
			end
			KIND_FREE: begin
				if (word_idx < MAP_WORDS) begin
					frame_free[word_idx][bit_idx] = 1'b1;
					outcome.found = 1'b1;
				end
			end
			KIND_MARK_USED: begin
				if (word_idx < MAP_WORDS) begin
					frame_free[word_idx][bit_idx] = 1'b0;
					outcome.found = 1'b1;
				end
			end
			default: ;
		endcase
		return outcome;
	endfunction

	// Compare every response transfer against the oldest owed response.
	always @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			if (owed_responses.size() == 0) begin
				flag_mismatch("unexpected response, granted_page", -1, rsp.granted_page);
			end else begin
				owed_head = owed_responses.pop_front();
				if (rsp.found !== owed_head.found)
					flag_mismatch("found", owed_head.found, rsp.found);
				if (rsp.granted_page !== owed_head.granted_page)
					flag_mismatch("granted_page", owed_head.granted_page, rsp.granted_page);
			end
		end
	end

	// Send one request. Valid stays high between back-to-back requests and drops
	// only for a random gap; the response is predicted at the transfer edge.
	task automatic send_request(input logic [1:0] kind, input logic [PAGE_W-1:0] page);
		req_t item;
		item.kind = kind;
		item.page_number = page;
		if ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_gap_pct);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (!req_ready);
		owed_responses.push_back(apply_request(item));
	endtask

	// Hold off the request side until every owed response has come back.
	task automatic wait_until_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (owed_responses.size() != 0);
	endtask

	// Requests against the map as it comes out of reset: nothing to allocate.
	task automatic test_empty_map();
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, PAGE_W'(TOP_PAGE));
		send_request(KIND_MARK_USED, '0);
		send_request(KIND_UNUSED, PAGE_W'(TOP_PAGE));
		send_request(KIND_UNUSED, '0);
	endtask

	// Edge pages, word boundaries, repeated free and mark-used, alternating bit patterns.
	task automatic test_corner_pages();
		// deepest page only: the scan must run to the last word
		send_request(KIND_FREE, PAGE_W'(TOP_PAGE));
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		// last bit of word 0, first bit of word 1, then page 0
		send_request(KIND_FREE, PAGE_W'(31));
		send_request(KIND_FREE, PAGE_W'(32));
		send_request(KIND_FREE, '0);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		// alternating patterns; free one of them twice
		send_request(KIND_FREE, PAGE_W'(16'h5555));
		send_request(KIND_FREE, PAGE_W'(16'h2AAA));
		send_request(KIND_FREE, PAGE_W'(16'h5555));
		send_request(KIND_ALLOC, PAGE_W'(TOP_PAGE));
		send_request(KIND_ALLOC, '0);
		send_request(KIND_ALLOC, '0);
		// free then mark used again leaves nothing to grant
		send_request(KIND_FREE, PAGE_W'(7));
		send_request(KIND_MARK_USED, PAGE_W'(7));
		send_request(KIND_ALLOC, '0);
		send_request(KIND_MARK_USED, PAGE_W'(TOP_PAGE));
	endtask

	// Mostly pages inside a small window so allocations find work; the rest spread
	// over the whole page range to plant free pages deep in the map.
	task automatic send_random_request();
		int roll;
		logic [1:0] kind;
		logic [PAGE_W-1:0] page;
		roll = $urandom_range(99);
		if (roll < 42)
			kind = KIND_ALLOC;
		else if (roll < 80)
			kind = KIND_FREE;
		else if (roll < 95)
			kind = KIND_MARK_USED;
		else
			kind = KIND_UNUSED;
		if ($urandom_range(9) < 7)
			page = PAGE_W'(hot_base + $urandom_range(HOT_SPAN - 1));
		else
			page = PAGE_W'($urandom());
		send_request(kind, page);
	endtask

	task automatic test_random_traffic(input int count, input int sender_pct,
			input int receiver_pct, input int unsigned window_base);
		send_gap_pct = sender_pct;
		rcv_stall_pct = receiver_pct;
		hot_base = window_base;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				wait_until_drained();
			send_random_request();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_map();
		test_corner_pages();
		test_random_traffic(430, 24, 51, 0);
		test_random_traffic(430, 51, 24, $urandom_range(TOP_PAGE + 1 - HOT_SPAN));
		test_random_traffic(430, 0, 0, TOP_PAGE + 1 - HOT_SPAN);
		req_valid <= 1'b0;
		while (owed_responses.size() != 0)
			@(posedge clk);
		// let any stray response show up
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("page_frame_bitmap_allocator_core_tb passed");
		else
			$display("page_frame_bitmap_allocator_core_tb failed");
		$finish;
	end

endmodule
